// File: rtl/core/escaped_frame_encoder_crc16_top_macros.svh
// ---------------------------------------------------------------------------
// escaped_frame_encoder_crc16_top_macros
// Assertion macros shared by the encoder's checker.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_ENCODER_CRC16_TOP_MACROS_SVH
`define ESCAPED_FRAME_ENCODER_CRC16_TOP_MACROS_SVH

// same-cycle implication
`define EFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked during reset as well
`define EFE_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/efe_pkg.sv
// ---------------------------------------------------------------------------
// efe_pkg
// Types, codes and the CRC step for the escaped frame encoder.
// ---------------------------------------------------------------------------
package efe_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned JOB_BYTES       = 5;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] START_RESET  = 8'd126;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  localparam logic REQ_HDR  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TOO_LONG    = 2'd1;
  localparam logic [1:0] ST_NO_HDR      = 2'd2;
  localparam logic [1:0] ST_HDR_IN_FRM  = 2'd3;

  localparam logic [7:0] CFG_START  = 8'd0;
  localparam logic [7:0] CFG_ESCAPE = 8'd1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  cmd;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // one classified item: literal bytes, a mask of those that feed the CRC, and whether the CRC tail follows
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic [JOB_BYTES-1:0]      crc_mask;
    logic                      crc_init;
    logic                      close;
    logic [1:0]                status;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/efe_front.sv
// ---------------------------------------------------------------------------
// efe_front
// Takes items, checks them against frame state and builds emit jobs.
// ---------------------------------------------------------------------------
module efe_front #(
  parameter int unsigned MAX_PAYLOAD = efe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  efe_pkg::in_item_t in_data,
  input  logic              accept,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output efe_pkg::job_t     job
);

  logic        frame_open;
  logic [15:0] remaining;
  logic [7:0]  seq;
  logic [7:0]  start_byte;
  logic [7:0]  escape_byte;

  logic frame_open_next;
  logic [15:0] remaining_next;
  logic [7:0]  seq_next;
  logic        esc;

  assign esc = (in_data.data_byte == start_byte) || (in_data.data_byte == escape_byte);

  always_comb begin
    job             = '0;
    frame_open_next = frame_open;
    remaining_next  = remaining;
    seq_next        = seq;
    job.count       = 3'd1;
    job.status      = efe_pkg::ST_OK;
    if (in_data.req_type == efe_pkg::REQ_HDR) begin
      if (frame_open) begin
        job.status = efe_pkg::ST_HDR_IN_FRM;
      end else if (32'(in_data.length) > MAX_PAYLOAD) begin
        job.status = efe_pkg::ST_TOO_LONG;
      end else begin
        job.bytes[0] = start_byte;
        job.bytes[1] = in_data.length[15:8];
        job.bytes[2] = in_data.length[7:0];
        job.bytes[3] = seq;
        job.bytes[4] = in_data.cmd;
        job.count    = 3'd5;
        job.crc_mask = 5'b11110;
        job.crc_init = 1'b1;
        if (in_data.length == 16'd0) begin
          job.close = 1'b1;
          seq_next  = seq + 8'd1;
        end else begin
          frame_open_next = 1'b1;
          remaining_next  = in_data.length;
        end
      end
    end else begin
      if (!frame_open) begin
        job.status = efe_pkg::ST_NO_HDR;
      end else begin
        if (esc) begin
          job.bytes[0] = escape_byte;
          job.bytes[1] = in_data.data_byte;
          job.count    = 3'd2;
          job.crc_mask = 5'b00010;
        end else begin
          job.bytes[0] = in_data.data_byte;
          job.crc_mask = 5'b00001;
        end
        remaining_next = remaining - 16'd1;
        if (remaining == 16'd1) begin
          job.close       = 1'b1;
          frame_open_next = 1'b0;
          seq_next        = seq + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      remaining   <= '0;
      seq         <= '0;
      start_byte  <= efe_pkg::START_RESET;
      escape_byte <= efe_pkg::ESCAPE_RESET;
    end else begin
      if (accept && in_valid) begin
        frame_open <= frame_open_next;
        remaining  <= remaining_next;
        seq        <= seq_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          efe_pkg::CFG_START:  start_byte  <= cfg_data;
          efe_pkg::CFG_ESCAPE: escape_byte <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/efe_queue.sv
// ---------------------------------------------------------------------------
// efe_queue
// Short job queue between the classifier and the byte emitter.
// ---------------------------------------------------------------------------
module efe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  efe_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output efe_pkg::job_t rd_job
);

  localparam int unsigned AW = (efe_pkg::QUEUE_DEPTH > 1) ? $clog2(efe_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(efe_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(efe_pkg::QUEUE_DEPTH - 1);

  efe_pkg::job_t mem [efe_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(efe_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/efe_back.sv
// ---------------------------------------------------------------------------
// efe_back
// Emits one byte per cycle from the head job while out_stall is low, runs the CRC, appends it at frame end.
// ---------------------------------------------------------------------------
module efe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  efe_pkg::job_t      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output efe_pkg::out_item_t out_data
);

  logic [2:0]  pos;
  logic [15:0] crc;

  logic        adv;
  logic        in_lit;
  logic        in_crc_hi;
  logic        done;
  logic [7:0]  byte_cur;
  logic [15:0] crc_base;
  logic        feed;

  assign adv       = !out_valid || !out_stall;
  assign in_lit    = (pos < job.count);
  assign in_crc_hi = (pos == job.count);
  assign done      = job.close ? (pos == job.count + 3'd1) : (pos == job.count - 3'd1);
  assign pop       = adv && job_valid && done;
  assign crc_base  = (job.crc_init && pos == 3'd0) ? efe_pkg::CRC_INIT : crc;

  always_comb begin
    feed = 1'b0;
    case (pos)
      3'd0: begin byte_cur = job.bytes[0]; feed = job.crc_mask[0]; end
      3'd1: begin byte_cur = job.bytes[1]; feed = job.crc_mask[1]; end
      3'd2: begin byte_cur = job.bytes[2]; feed = job.crc_mask[2]; end
      3'd3: begin byte_cur = job.bytes[3]; feed = job.crc_mask[3]; end
      3'd4: begin byte_cur = job.bytes[4]; feed = job.crc_mask[4]; end
      default: byte_cur = 8'h00;
    endcase
    if (!in_lit) begin
      feed     = 1'b0;
      byte_cur = in_crc_hi ? crc[15:8] : crc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= efe_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= job_valid;
      if (job_valid) begin
        pos <= done ? 3'd0 : pos + 3'd1;
        if (in_lit) begin
          crc <= feed ? efe_pkg::crc_feed(crc_base, byte_cur) : crc_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && job_valid) begin
      out_data.out_byte  <= byte_cur;
      out_data.frame_end <= job.close && !in_lit && !in_crc_hi;
      out_data.status    <= job.status;
      out_data.last      <= done;
    end
  end

endmodule

// File: rtl/core/escaped_frame_encoder_crc16_top.sv
// ---------------------------------------------------------------------------
// escaped_frame_encoder_crc16_top
// Byte-stuffed frame encoder with CRC-16/CCITT-FALSE.
// ---------------------------------------------------------------------------
// An accepted item is written as a job into the job queue; the emitter then registers its bytes onto out_data.
// Output: one byte per cycle from the emitter while out_stall is low; data items give
// 1 to 4 bytes (escaped last byte plus CRC), headers 5 (7 with empty payload), errors 1.
// Input stalls only while the two-entry job queue is full.
// Reset (rst, sync): frame closed, sequence 0, CRC all ones, markers 126/125.
module escaped_frame_encoder_crc16_top #(
  parameter int unsigned MAX_PAYLOAD = efe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  efe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output efe_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  efe_pkg::job_t new_job;
  efe_pkg::job_t head_job;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          accept;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  efe_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .accept   (accept),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job      (new_job)
  );

  efe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .wr_job  (new_job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rd_job  (head_job)
  );

  efe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_valid),
    .job      (head_job),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/efe_checker.sv
// ---------------------------------------------------------------------------
// efe_checker
// Port-level checks on the encoder output stream.
// ---------------------------------------------------------------------------
`include "escaped_frame_encoder_crc16_top_macros.svh"

module efe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input efe_pkg::out_item_t out_data
);

  `EFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")
  `EFE_ASSERT_NOW(a_end_last, out_valid && out_data.frame_end, out_data.last && (out_data.status == efe_pkg::ST_OK), "frame end not last ok result")
  `EFE_ASSERT_NOW(a_err_shape, out_valid && (out_data.status != efe_pkg::ST_OK), out_data.last && !out_data.frame_end && (out_data.out_byte == 8'h00), "malformed error result")
  `EFE_ASSERT_ALWAYS(a_rst_idle, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind escaped_frame_encoder_crc16_top efe_checker u_efe_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
